// File: rtl/core/pid_pkg.sv
`default_nettype none

package pid_pkg;

   localparam int DATA_W     = 16;
   localparam int ERR_W      = 17;
   localparam int INTEG_W    = 48;
   localparam int MUL_A_W    = 17;
   localparam int MUL_B_W    = 25;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = 64;
   localparam int FRAC_SHIFT = 20;
   localparam int ROUND_W    = ACC_W - FRAC_SHIFT;
   localparam int DERIV_W    = 39;
   localparam int SPLIT      = 24;

   // The divider works on |diff| * 2^20 and retires two quotient bits a cycle.
   localparam int DIV_W      = 38;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

   localparam int CSR_IDX_W  = 3;

   localparam logic signed [DATA_W-1:0] OUT_MIN_RESET = 16'sh8000;
   localparam logic signed [DATA_W-1:0] OUT_MAX_RESET = 16'sh7FFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P    = 3'd0,
      CSR_GAIN_I    = 3'd1,
      CSR_GAIN_D    = 3'd2,
      CSR_OUT_MIN   = 3'd3,
      CSR_OUT_MAX   = 3'd4,
      CSR_LIMITS_ON = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] gain_p;
      logic signed [DATA_W-1:0] gain_i;
      logic signed [DATA_W-1:0] gain_d;
      logic signed [DATA_W-1:0] out_min;
      logic signed [DATA_W-1:0] out_max;
      logic                     limits_on;
   } cfg_type;

   typedef enum logic [2:0] {
      MUL_ERR_DT = 3'd0,
      MUL_P      = 3'd1,
      MUL_I_LO   = 3'd2,
      MUL_I_HI   = 3'd3,
      MUL_D_LO   = 3'd4,
      MUL_D_HI   = 3'd5
   } mul_op_type;

   typedef enum logic [2:0] {
      ACC_NONE  = 3'd0,
      ACC_CLEAR = 3'd1,
      ACC_SH0   = 3'd2,
      ACC_SH4   = 3'd3,
      ACC_SH12  = 3'd4,
      ACC_SH24  = 3'd5,
      ACC_SH28  = 3'd6
   } acc_op_type;

   typedef struct packed {
      logic       load_in;
      logic       div_start;
      logic       mul_en;
      mul_op_type mul_op;
      acc_op_type acc_op;
      logic       integ_update;
      logic       deriv_load;
      logic       round_load;
      logic       rsp_load;
      logic       clear_state;
      logic       last_update;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/core/pid_div.sv
`default_nettype none

module pid_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [pid_pkg::DIV_W-1:0] dividend,
   input  wire logic [15:0]               divisor,
   output logic                           busy,
   output logic [pid_pkg::DIV_W-1:0]      quotient
);
   import pid_pkg::*;

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          divisor_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;

   // Restoring division; the dividend shifts out of the top of the quotient register
   // while quotient bits enter at the bottom.
   always_comb begin
      logic [16:0] trial;
      logic [16:0] diff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int k = 0; k < DIV_STEPS; k++) begin
         trial  = {rem_in, quo_in[DIV_W-1]};
         quo_in = {quo_in[DIV_W-2:0], 1'b0};
         diff   = trial - {1'b0, divisor_ff};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in    = diff[15:0];
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: rtl/core/pid_csr.sv
`default_nettype none

module pid_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [pid_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                   csr_data,
   output pid_pkg::cfg_type                   cfg
);
   import pid_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p    <= '0;
         cfg_ff.gain_i    <= '0;
         cfg_ff.gain_d    <= '0;
         cfg_ff.out_min   <= OUT_MIN_RESET;
         cfg_ff.out_max   <= OUT_MAX_RESET;
         cfg_ff.limits_on <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:    cfg_ff.gain_p    <= csr_data;
            CSR_GAIN_I:    cfg_ff.gain_i    <= csr_data;
            CSR_GAIN_D:    cfg_ff.gain_d    <= csr_data;
            CSR_OUT_MIN:   cfg_ff.out_min   <= csr_data;
            CSR_OUT_MAX:   cfg_ff.out_max   <= csr_data;
            CSR_LIMITS_ON: cfg_ff.limits_on <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/pid_datapath.sv
`default_nettype none

module pid_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pid_pkg::cfg_type       cfg,
   input  wire pid_pkg::cmd_type       cmd,
   output pid_pkg::status_type         status,
   input  wire logic signed [15:0]     req_target,
   input  wire logic signed [15:0]     req_measured,
   input  wire logic [15:0]            req_time_step,
   output logic signed [15:0]          rsp_correction
);
   import pid_pkg::*;

   logic signed [ERR_W-1:0]   err_ff;
   logic [15:0]               dt_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [ERR_W-1:0]   last_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [DERIV_W-1:0] deriv_ff;
   logic signed [ROUND_W-1:0] round_ff;
   logic signed [DATA_W-1:0]  rsp_ff;

   logic signed [ERR_W:0]     diff;
   logic [ERR_W:0]            diff_mag;
   logic [DIV_W-1:0]          dividend;
   logic                      div_busy;
   logic [DIV_W-1:0]          quotient;
   logic signed [DERIV_W-1:0] deriv_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [ACC_W-1:0]   addend;
   logic signed [INTEG_W:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [ACC_W-1:0]   round_sum;
   logic signed [DATA_W-1:0]  sat_v;

   assign diff     = {err_ff[ERR_W-1], err_ff} - {last_ff[ERR_W-1], last_ff};
   assign diff_mag = diff[ERR_W] ? -diff : diff;
   assign dividend = {1'b0, diff_mag[ERR_W-1:0], {FRAC_SHIFT{1'b0}}};

   pid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (dt_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign status.div_busy = div_busy;

   // The quotient is a magnitude; the sign of the error difference is put back here.
   always_comb begin
      if (dt_ff == '0) begin
         deriv_in = '0;
      end else if (diff[ERR_W]) begin
         deriv_in = -$signed({1'b0, quotient});
      end else begin
         deriv_in = $signed({1'b0, quotient});
      end
   end

   // The wide products are split into a signed upper and an unsigned lower half.
   always_comb begin
      case (cmd.mul_op)
         MUL_ERR_DT: begin
            mul_a = err_ff;
            mul_b = {9'b0, dt_ff};
         end
         MUL_P: begin
            mul_a = {cfg.gain_p[DATA_W-1], cfg.gain_p};
            mul_b = {{8{err_ff[ERR_W-1]}}, err_ff};
         end
         MUL_I_LO: begin
            mul_a = {cfg.gain_i[DATA_W-1], cfg.gain_i};
            mul_b = {1'b0, integ_ff[SPLIT-1:0]};
         end
         MUL_I_HI: begin
            mul_a = {cfg.gain_i[DATA_W-1], cfg.gain_i};
            mul_b = {integ_ff[INTEG_W-1], integ_ff[INTEG_W-1:SPLIT]};
         end
         MUL_D_LO: begin
            mul_a = {cfg.gain_d[DATA_W-1], cfg.gain_d};
            mul_b = {1'b0, deriv_ff[SPLIT-1:0]};
         end
         MUL_D_HI: begin
            mul_a = {cfg.gain_d[DATA_W-1], cfg.gain_d};
            mul_b = {{10{deriv_ff[DERIV_W-1]}}, deriv_ff[DERIV_W-1:SPLIT]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      case (cmd.acc_op)
         ACC_SH0:  addend = ACC_W'(prod_ff);
         ACC_SH4:  addend = ACC_W'(prod_ff) <<< 4;
         ACC_SH12: addend = ACC_W'(prod_ff) <<< 12;
         ACC_SH24: addend = ACC_W'(prod_ff) <<< 24;
         ACC_SH28: addend = ACC_W'(prod_ff) <<< 28;
         default:  addend = '0;
      endcase
   end

   assign integ_sum = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'($signed(prod_ff[32:0]));

   always_comb begin
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_in = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
   end

   // Round half up: add one half and take the floor by an arithmetic shift.
   assign round_sum = acc_ff + (ACC_W'(1) <<< (FRAC_SHIFT - 1));

   always_comb begin
      if (round_ff > ROUND_W'(OUT_MAX_RESET)) begin
         sat_v = OUT_MAX_RESET;
      end else if (round_ff < ROUND_W'(OUT_MIN_RESET)) begin
         sat_v = OUT_MIN_RESET;
      end else begin
         sat_v = round_ff[DATA_W-1:0];
      end
      if (cfg.limits_on) begin
         if (sat_v > cfg.out_max) begin
            sat_v = cfg.out_max;
         end
         if (sat_v < cfg.out_min) begin
            sat_v = cfg.out_min;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         last_ff  <= '0;
      end else if (cmd.clear_state) begin
         integ_ff <= '0;
         last_ff  <= '0;
      end else begin
         if (cmd.integ_update) begin
            integ_ff <= integ_in;
         end
         if (cmd.last_update) begin
            last_ff <= err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         err_ff <= {req_target[DATA_W-1], req_target} - {req_measured[DATA_W-1], req_measured};
         dt_ff  <= req_time_step;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.acc_op == ACC_CLEAR) begin
         acc_ff <= '0;
      end else if (cmd.acc_op != ACC_NONE) begin
         acc_ff <= acc_ff + addend;
      end
      if (cmd.deriv_load) begin
         deriv_ff <= deriv_in;
      end
      if (cmd.round_load) begin
         round_ff <= round_sum[ACC_W-1:FRAC_SHIFT];
      end
      if (cmd.rsp_load) begin
         rsp_ff <= cmd.clear_state ? '0 : sat_v;
      end
   end

   assign rsp_correction = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/pid_ctrl.sv
`default_nettype none

module pid_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_action,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire pid_pkg::status_type status,
   output pid_pkg::cmd_type         cmd
);
   import pid_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE     = 14'h0001,
      ST_ERR_DT   = 14'h0002,
      ST_PROP     = 14'h0004,
      ST_INT_LO   = 14'h0008,
      ST_INT_HI   = 14'h0010,
      ST_INT_ACC  = 14'h0020,
      ST_DIV_WAIT = 14'h0040,
      ST_DERIV    = 14'h0080,
      ST_DER_LO   = 14'h0100,
      ST_DER_HI   = 14'h0200,
      ST_DER_ACC  = 14'h0400,
      ST_ROUND    = 14'h0800,
      ST_OUT      = 14'h1000,
      ST_CLEAR    = 14'h2000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // The output register may be refilled in the cycle its transaction completes.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.mul_op = MUL_ERR_DT;
      cmd.acc_op = ACC_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = req_action ? ST_CLEAR : ST_ERR_DT;
            end
         end
         ST_ERR_DT: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_op    = MUL_ERR_DT;
            cmd.acc_op    = ACC_CLEAR;
            cmd.div_start = 1'b1;
            state_in      = ST_PROP;
         end
         ST_PROP: begin
            cmd.integ_update = 1'b1;
            cmd.mul_en       = 1'b1;
            cmd.mul_op       = MUL_P;
            state_in         = ST_INT_LO;
         end
         ST_INT_LO: begin
            cmd.acc_op = ACC_SH12;
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_I_LO;
            state_in   = ST_INT_HI;
         end
         ST_INT_HI: begin
            cmd.acc_op = ACC_SH0;
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_I_HI;
            state_in   = ST_INT_ACC;
         end
         ST_INT_ACC: begin
            cmd.acc_op = ACC_SH24;
            state_in   = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_DERIV;
            end
         end
         ST_DERIV: begin
            cmd.deriv_load = 1'b1;
            state_in       = ST_DER_LO;
         end
         ST_DER_LO: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_D_LO;
            state_in   = ST_DER_HI;
         end
         ST_DER_HI: begin
            cmd.acc_op = ACC_SH4;
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_D_HI;
            state_in   = ST_DER_ACC;
         end
         ST_DER_ACC: begin
            cmd.acc_op = ACC_SH28;
            state_in   = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_load = 1'b1;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.rsp_load    = 1'b1;
               cmd.last_update = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (slot_free) begin
               cmd.rsp_load    = 1'b1;
               cmd.clear_state = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/core/pid_controller_step.sv
// PID controller step with output clamp.
//
// Request channel (req_*): one transaction per control step. With req_action low the
// block forms error = target - measured, updates the saturating integral with
// error * time_step and the derivative with (error - previous error) / time_step,
// and returns kp*e + ki*integral + kd*derivative, rounded, saturated and optionally
// clamped. With req_action high it clears the integral and previous error and
// returns zero.
// Response channel (rsp_*): one transaction per request, in order, from an output
// register. A new request is taken while an earlier result still waits there.
// Configuration channel (csr_*): always ready; write only while the block is idle.
// The length of a control step is set mainly by the radix-4 restoring divider for the
// derivative and the single shared 17x25 multiplier; a new request is taken only
// once the previous one has loaded the output register. A clear step loads zero
// there from ST_CLEAR. If the receiver stalls, the result waits in the output
// register; one more request is still taken and computed, then holds in the
// controller, and no request after it is taken until the register frees.
// Reset (synchronous) clears the gains, sets the limits to the full 16-bit range,
// disables clamping and zeroes the integral and the previous error.

`default_nettype none

module pid_controller_step (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_action,
   input  wire logic signed [15:0]            req_target,
   input  wire logic signed [15:0]            req_measured,
   input  wire logic [15:0]                   req_time_step,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [15:0]                 rsp_correction,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [pid_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                   csr_data
);
   import pid_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   pid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   pid_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .req_target     (req_target),
      .req_measured   (req_measured),
      .req_time_step  (req_time_step),
      .rsp_correction (rsp_correction)
   );

endmodule

`default_nettype wire
